@@ design/gbn_pkg.sv @@
package gbn_pkg;

	// Default build-time sizes
	localparam int WINDOW_MAX_DEF   = 8;
	localparam int SEQ_BITS_DEF     = 8;
	localparam int PAYLOAD_BITS_DEF = 32;

	// Window size register
	localparam int          CFG_W     = 4;
	localparam logic [3:0]  WIN_RESET = 4'd8;

	// Request codes on the mode field
	localparam logic [1:0] MODE_SEND    = 2'd0;
	localparam logic [1:0] MODE_ACK     = 2'd1;
	localparam logic [1:0] MODE_TIMEOUT = 2'd2;

	// Result codes on the action field
	typedef enum logic [1:0] {
		ACT_REFUSE      = 2'd0,
		ACT_TRANSMIT    = 2'd1,
		ACT_TIMER_START = 2'd2,
		ACT_TIMER_STOP  = 2'd3
	} gbn_action_t;

	// Operations of the shared modular adder
	typedef enum logic [1:0] {
		ALU_ADD_SEQ  = 2'd0,
		ALU_SUB_SEQ  = 2'd1,
		ALU_ADD_SLOT = 2'd2
	} gbn_alu_op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEND,
		ST_SEND_TX,
		ST_ACK_CHK,
		ST_ACK_SLOT,
		ST_ACK_BASE,
		ST_TO_START,
		ST_TO_TX
	} gbn_state_t;

	// Adder operand width: holds a sequence number or a slot sum with a carry
	function automatic int gbn_alu_opw(input int sb, input int wm);
		int sw;
		sw = (wm > 1) ? $clog2(wm) : 1;
		return (sb > sw + 1) ? sb : sw + 1;
	endfunction

endpackage

@@ design/go_back_n_sender.sv @@
// Go-Back-N ARQ sender.
// Requests come in on start/busy: an item is taken at a clock edge where start is
// high and busy is low. mode selects send (payload on message_word), cumulative
// acknowledgement (ack_number, ack_checksum_ok) or timer expiry.
// Results leave on result_valid with action, seq_number, packet_word and last;
// each one is shown for one cycle, and last marks the final result of a request.
// The receiver cannot stall; results are never held back.
// The window size register is written over cfg_valid/cfg_ready/cfg_data while idle.
// Timing: results come from a register and follow one per cycle within an item.
// The first result of a send is registered from ST_SEND (a refusal or a timer start) or
// else from ST_SEND_TX, that of a timeout (if any packet is outstanding) from ST_TO_START
// and that of a good acknowledgement from ST_ACK_SLOT, after ST_ACK_CHK. busy stays high
// until the sequencer is back in ST_IDLE, so a new item is taken only once the current
// one is through; a bad checksum or an unused mode is dropped at once and the next item
// can be taken at the next edge.
// Every sequence and slot update but the retransmit sequence count goes through one
// shared modular adder, one operation per cycle; a retransmit burst is paced by the
// single payload store read port, one packet per cycle.
// Reset: window base and next sequence are 1, nothing outstanding, window size 8.
// The payload store is not cleared; only written entries are ever read.
module go_back_n_sender
	import gbn_pkg::*;
#(
	parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
	parameter int SEQ_BITS     = SEQ_BITS_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              mode,
	input  logic [PAYLOAD_BITS-1:0] message_word,
	input  logic [SEQ_BITS-1:0]     ack_number,
	input  logic                    ack_checksum_ok,
	output logic                    result_valid,
	output logic [1:0]              action,
	output logic [SEQ_BITS-1:0]     seq_number,
	output logic [PAYLOAD_BITS-1:0] packet_word,
	output logic                    last,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam int SEQ_LIM = (1 << SEQ_BITS) - 1;
	localparam int WIN_LIM = (WINDOW_MAX < SEQ_LIM) ? WINDOW_MAX : SEQ_LIM;
	localparam int CNT_W   = (WIN_LIM > 1) ? $clog2(WIN_LIM + 1) : 1;
	localparam int SLOT_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int OPW     = (SEQ_BITS > SLOT_W + 1) ? SEQ_BITS : SLOT_W + 1;

	gbn_state_t state_q, state_d;

	// Protocol state
	logic [CFG_W-1:0]    win_q;
	logic [SEQ_BITS-1:0] base_q;
	logic [SEQ_BITS-1:0] next_q;
	logic [CNT_W-1:0]    count_q;
	logic [SLOT_W-1:0]   slot_q;

	// Per-request working registers
	logic [PAYLOAD_BITS-1:0] word_q;
	logic [SEQ_BITS-1:0]     ack_q;
	logic [CNT_W-1:0]        adv_q;
	logic [SLOT_W-1:0]       ptr_q;
	logic [SEQ_BITS-1:0]     rseq_q;
	logic [CNT_W-1:0]        left_q;

	// Shared adder and store hookup
	gbn_alu_op_t             alu_op;
	logic [OPW-1:0]          alu_a;
	logic [OPW-1:0]          alu_b;
	logic [OPW-1:0]          alu_y;
	logic                    store_we;
	logic [SLOT_W-1:0]       store_raddr;
	logic [PAYLOAD_BITS-1:0] store_rdata;

	// Result staging
	logic                    emit;
	gbn_action_t             emit_action;
	logic [SEQ_BITS-1:0]     emit_seq;
	logic [PAYLOAD_BITS-1:0] emit_word;
	logic                    emit_last;
	logic                    res_valid_q;
	gbn_action_t             res_action_q;
	logic [SEQ_BITS-1:0]     res_seq_q;
	logic [PAYLOAD_BITS-1:0] res_word_q;
	logic                    res_last_q;

	logic [CNT_W-1:0] eff_win;
	logic             accept;
	logic             ack_hit;

	gbn_alu #(
		.SEQ_BITS   (SEQ_BITS),
		.WINDOW_MAX (WINDOW_MAX)
	) u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	gbn_store #(
		.WINDOW_MAX   (WINDOW_MAX),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (alu_y[SLOT_W-1:0]),
		.wdata (word_q),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign ack_hit   = (alu_y < OPW'(count_q));

	// Clamp the window register to the usable range
	always_comb begin
		if (win_q == '0) begin
			eff_win = CNT_W'(1);
		end else if (int'(win_q) > WIN_LIM) begin
			eff_win = CNT_W'(WIN_LIM);
		end else begin
			eff_win = CNT_W'(win_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, adder operation, store access and result
	always_comb begin
		state_d     = state_q;
		alu_op      = ALU_ADD_SEQ;
		alu_a       = '0;
		alu_b       = '0;
		store_we    = 1'b0;
		store_raddr = ptr_q;
		emit        = 1'b0;
		emit_action = ACT_TRANSMIT;
		emit_seq    = next_q;
		emit_word   = '0;
		emit_last   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (mode == MODE_SEND) begin
						state_d = ST_SEND;
					end else if (mode == MODE_ACK && ack_checksum_ok) begin
						state_d = ST_ACK_CHK;
					end else if (mode == MODE_TIMEOUT) begin
						state_d = ST_TO_START;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SEND: begin
				alu_op = ALU_ADD_SLOT;
				alu_a  = OPW'(slot_q);
				alu_b  = OPW'(count_q);
				if (count_q >= eff_win) begin
					emit        = 1'b1;
					emit_action = ACT_REFUSE;
					emit_seq    = next_q;
					emit_last   = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					store_we = 1'b1;
					if (count_q == '0) begin
						emit        = 1'b1;
						emit_action = ACT_TIMER_START;
						emit_seq    = base_q;
					end
					state_d = ST_SEND_TX;
				end
			end
			ST_SEND_TX: begin
				alu_op      = ALU_ADD_SEQ;
				alu_a       = OPW'(next_q);
				alu_b       = OPW'(1);
				emit        = 1'b1;
				emit_action = ACT_TRANSMIT;
				emit_seq    = next_q;
				emit_word   = word_q;
				emit_last   = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_ACK_CHK: begin
				alu_op  = ALU_SUB_SEQ;
				alu_a   = OPW'(ack_q);
				alu_b   = OPW'(base_q);
				state_d = ack_hit ? ST_ACK_SLOT : ST_IDLE;
			end
			ST_ACK_SLOT: begin
				alu_op      = ALU_ADD_SLOT;
				alu_a       = OPW'(slot_q);
				alu_b       = OPW'(adv_q);
				emit        = 1'b1;
				emit_action = ACT_TIMER_STOP;
				emit_seq    = ack_q;
				emit_last   = (adv_q == count_q);
				state_d     = ST_ACK_BASE;
			end
			ST_ACK_BASE: begin
				alu_op = ALU_ADD_SEQ;
				alu_a  = OPW'(ack_q);
				alu_b  = OPW'(1);
				if (count_q != '0) begin
					emit        = 1'b1;
					emit_action = ACT_TIMER_START;
					emit_seq    = alu_y[SEQ_BITS-1:0];
					emit_last   = 1'b1;
				end
				state_d = ST_IDLE;
			end
			ST_TO_START: begin
				alu_op      = ALU_ADD_SLOT;
				alu_a       = OPW'(slot_q);
				alu_b       = OPW'(1);
				store_raddr = slot_q;
				if (count_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					emit        = 1'b1;
					emit_action = ACT_TIMER_START;
					emit_seq    = base_q;
					state_d     = ST_TO_TX;
				end
			end
			ST_TO_TX: begin
				alu_op      = ALU_ADD_SLOT;
				alu_a       = OPW'(ptr_q);
				alu_b       = OPW'(1);
				store_raddr = ptr_q;
				emit        = 1'b1;
				emit_action = ACT_TRANSMIT;
				emit_seq    = rseq_q;
				emit_word   = store_rdata;
				emit_last   = (left_q == CNT_W'(1));
				if (left_q == CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Protocol state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= WIN_RESET;
			base_q      <= SEQ_BITS'(1);
			next_q      <= SEQ_BITS'(1);
			count_q     <= '0;
			slot_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= emit;
			if (cfg_valid && cfg_ready) begin
				win_q <= cfg_data;
			end
			unique case (state_q)
				ST_SEND_TX: begin
					next_q  <= alu_y[SEQ_BITS-1:0];
					count_q <= count_q + CNT_W'(1);
				end
				ST_ACK_SLOT: begin
					slot_q  <= alu_y[SLOT_W-1:0];
					count_q <= count_q - adv_q;
				end
				ST_ACK_BASE: begin
					base_q <= alu_y[SEQ_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers and result payload
	always_ff @(posedge clk) begin
		res_action_q <= emit_action;
		res_seq_q    <= emit_seq;
		res_word_q   <= emit_word;
		res_last_q   <= emit_last;
		if (accept) begin
			word_q <= message_word;
			ack_q  <= ack_number;
		end
		if (state_q == ST_ACK_CHK) begin
			adv_q <= alu_y[CNT_W-1:0] + CNT_W'(1);
		end
		if (state_q == ST_TO_START) begin
			rseq_q <= base_q;
			left_q <= count_q;
		end
		if (state_q == ST_TO_TX) begin
			rseq_q <= rseq_q + SEQ_BITS'(1);
			left_q <= left_q - CNT_W'(1);
		end
		if (state_q == ST_TO_START || state_q == ST_TO_TX) begin
			ptr_q <= alu_y[SLOT_W-1:0];
		end
	end

	assign result_valid = res_valid_q;
	assign action       = res_action_q;
	assign seq_number   = res_seq_q;
	assign packet_word  = res_word_q;
	assign last         = res_last_q;

`ifndef SYNTHESIS
	// Outstanding count and sequence pointers agree between requests
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (next_q == SEQ_BITS'(base_q + SEQ_BITS'(count_q))))
		else $error("next sequence does not match base plus outstanding count");

	// The window never holds more than its limit
	assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= WIN_LIM)
		else $error("outstanding count above window limit");

	// The base slot pointer stays inside the store
	assert property (@(posedge clk) disable iff (!arst_n)
		int'(slot_q) < WINDOW_MAX)
		else $error("base slot outside payload store");

	// A retransmit burst always has a packet left to send
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TO_TX) |-> (left_q != '0))
		else $error("retransmit with no packet left");

	// A refused send is the only result of its request
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && action == ACT_REFUSE) |-> (last && state_q == ST_IDLE))
		else $error("refused send not closing its request");
`endif

endmodule

@@ design/gbn_alu.sv @@
module gbn_alu
	import gbn_pkg::*;
#(
	parameter int SEQ_BITS   = SEQ_BITS_DEF,
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  gbn_alu_op_t                              op,
	input  logic [gbn_alu_opw(SEQ_BITS, WINDOW_MAX)-1:0] a,
	input  logic [gbn_alu_opw(SEQ_BITS, WINDOW_MAX)-1:0] b,
	output logic [gbn_alu_opw(SEQ_BITS, WINDOW_MAX)-1:0] y
);

	localparam int OPW = gbn_alu_opw(SEQ_BITS, WINDOW_MAX);

	logic [OPW:0] sum;
	logic [OPW:0] slot_sum;

	// Add with one spare bit, then fold back into range for slot arithmetic
	always_comb begin
		sum      = {1'b0, a} + {1'b0, b};
		slot_sum = sum;
		if (sum >= (OPW + 1)'(WINDOW_MAX)) begin
			slot_sum = sum - (OPW + 1)'(WINDOW_MAX);
		end
		unique case (op)
			ALU_ADD_SEQ:  y = OPW'(sum[SEQ_BITS-1:0]);
			ALU_SUB_SEQ:  y = OPW'(SEQ_BITS'(a[SEQ_BITS-1:0] - b[SEQ_BITS-1:0]));
			ALU_ADD_SLOT: y = slot_sum[OPW-1:0];
			default:      y = '0;
		endcase
	end

endmodule

@@ design/gbn_store.sv @@
module gbn_store
	import gbn_pkg::*;
#(
	parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic                                           clk,
	input  logic                                           we,
	input  logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] waddr,
	input  logic [PAYLOAD_BITS-1:0]                        wdata,
	input  logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] raddr,
	output logic [PAYLOAD_BITS-1:0]                        rdata
);

	logic [PAYLOAD_BITS-1:0] mem_q [WINDOW_MAX];

	// Write the stored payload of a newly sent packet
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read every cycle; data is registered and ready in the cycle after the address
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
